FILE: rtl/core/bgm_pkg.sv
// ----------------------------------------------------------------------------
// bgm_pkg: shared types and constants of the background model classifier
// Widths of the per-pixel model entry, opcodes and register indexes.
// ----------------------------------------------------------------------------
package bgm_pkg;

  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned PIXELS    = 2 ** ADDR_W;
  localparam int unsigned LEARN_MAX = 1024;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned CNT_W     = $clog2(LEARN_MAX + 1);
  localparam int unsigned SUM_W     = $clog2(LEARN_MAX * 255 + 1);
  localparam int unsigned SPREAD_W  = SUM_W + 1;
  localparam int unsigned SCALE_W   = 8;
  localparam int unsigned PROD_W    = SPREAD_W + SCALE_W;
  localparam int unsigned NP_W      = CNT_W + CH_W;
  localparam int unsigned CMP_A_W   = (SUM_W > NP_W) ? SUM_W + 4 : NP_W + 4;
  localparam int unsigned CMP_W     = ((CMP_A_W > PROD_W) ? CMP_A_W : PROD_W) + 1;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = SCALE_W;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_SCALE  = 1'd1;

  localparam logic [SCALE_W-1:0] HIGH_SCALE_RST = 8'd112;
  localparam logic [SCALE_W-1:0] LOW_SCALE_RST  = 8'd96;

  localparam logic OP_LEARN    = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [NUM_CH-1:0][CH_W-1:0]  prev;
    logic [NUM_CH-1:0][SUM_W-1:0] sum;
    logic [NUM_CH-1:0][SUM_W-1:0] diff;
  } entry_t;

endpackage

FILE: rtl/core/bgm_in_if.sv
// ----------------------------------------------------------------------------
// bgm_in_if: pixel input channel
// Valid/ready channel carrying one pixel beat with its opcode.
// ----------------------------------------------------------------------------
interface bgm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [15:0]                  pixel_index;
  logic [bgm_pkg::CH_W-1:0]     chan0;
  logic [bgm_pkg::CH_W-1:0]     chan1;
  logic [bgm_pkg::CH_W-1:0]     chan2;
  logic                         frame_last;

  modport source (output valid, opcode, pixel_index, chan0, chan1, chan2, frame_last,
                  input ready);
  modport sink (input valid, opcode, pixel_index, chan0, chan1, chan2, frame_last,
                output ready);
endinterface

FILE: rtl/core/bgm_out_if.sv
// ----------------------------------------------------------------------------
// bgm_out_if: result channel
// Valid/ready channel carrying one result beat per pixel beat.
// ----------------------------------------------------------------------------
interface bgm_out_if;
  logic valid;
  logic ready;
  logic foreground;
  logic learn_ignored;

  modport source (output valid, foreground, learn_ignored, input ready);
  modport sink (input valid, foreground, learn_ignored, output ready);
endinterface

FILE: rtl/core/background_model_pixel_classifier.sv
// ----------------------------------------------------------------------------
// background_model_pixel_classifier: averaging background model
// Learns per-pixel channel sums and difference sums, classifies pixels.
//
//   port group | dir | beat content
//   in_bus     | in  | opcode, pixel_index, chan0..chan2, frame_last
//   out_bus    | out | foreground, learn_ignored
//   cfg_*      | in  | register index and data, write only
//
// One beat per cycle is taken unless out_bus stalls or the store is clearing.
// The rate is set by the model store: one read and one write port; a learned
// entry is written back as stage 1 advances and is forwarded to the next beat.
// After reset a clearing pass zeroes all 65536 store entries; in_bus.ready
// stays low meanwhile. A stalled out_bus fills the stages, then drops ready.
// ----------------------------------------------------------------------------
module background_model_pixel_classifier (
  input  logic                             clk,
  input  logic                             rst_n,
  bgm_in_if.sink                           in_bus,
  bgm_out_if.source                        out_bus,
  input  logic                             cfg_we,
  input  logic [bgm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bgm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned NC  = bgm_pkg::NUM_CH;
  localparam int unsigned CW  = bgm_pkg::CH_W;
  localparam int unsigned SW  = bgm_pkg::SUM_W;
  localparam int unsigned PW  = bgm_pkg::PROD_W;
  localparam int unsigned NPW = bgm_pkg::NP_W;
  localparam int unsigned MW  = bgm_pkg::CMP_W;

  // configuration
  logic [bgm_pkg::SCALE_W-1:0] high_scale_r;
  logic [bgm_pkg::SCALE_W-1:0] low_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_scale_r <= bgm_pkg::HIGH_SCALE_RST;
      low_scale_r  <= bgm_pkg::LOW_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bgm_pkg::REG_HIGH_SCALE: high_scale_r <= cfg_data;
        bgm_pkg::REG_LOW_SCALE:  low_scale_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clearing pass
  logic           clearing_r;
  bgm_pkg::addr_t clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == '1) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // stage control
  logic s1_v_r, s2_v_r, out_valid_r;
  logic out_load, s2_free, s1_free, s1_adv, accept;

  assign out_load = !out_valid_r || out_bus.ready;
  assign s2_free  = !s2_v_r || out_load;
  assign s1_free  = !s1_v_r || s2_free;
  assign s1_adv   = s1_v_r && s2_free;
  assign in_bus.ready = s1_free && !clearing_r;
  assign accept   = in_bus.valid && in_bus.ready;

  // stage 1 beat registers, read issued on accept
  logic                    s1_op_r;
  logic                    s1_last_r;
  bgm_pkg::addr_t          s1_addr_r;
  logic [NC-1:0][CW-1:0]   s1_px_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= in_bus.opcode;
      s1_last_r  <= in_bus.frame_last;
      s1_addr_r  <= in_bus.pixel_index[bgm_pkg::ADDR_W-1:0];
      s1_px_r[0] <= in_bus.chan0;
      s1_px_r[1] <= in_bus.chan1;
      s1_px_r[2] <= in_bus.chan2;
    end
  end

  // model store
  bgm_pkg::entry_t rd_data;
  bgm_pkg::entry_t cur;
  bgm_pkg::entry_t upd;
  bgm_pkg::entry_t wr_data;
  bgm_pkg::addr_t  wr_addr;
  logic            wr_en;
  logic            learn_wr;

  bgm_entry_ram u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (in_bus.pixel_index[bgm_pkg::ADDR_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // forward the most recent write
  logic            fw_v_r;
  bgm_pkg::addr_t  fw_addr_r;
  bgm_pkg::entry_t fw_data_r;

  assign cur = (fw_v_r && (fw_addr_r == s1_addr_r)) ? fw_data_r : rd_data;

  // frame bookkeeping
  logic                         first_frame_r;
  logic [bgm_pkg::CNT_W-1:0]    learned_r;
  logic                         s1_ign;
  logic                         s1_learn;

  assign s1_learn = (s1_op_r == bgm_pkg::OP_LEARN);
  assign s1_ign   = !first_frame_r &&
                    (learned_r >= bgm_pkg::CNT_W'(bgm_pkg::LEARN_MAX));

  always_comb begin
    upd = cur;
    for (int c = 0; c < NC; c++) begin
      upd.prev[c] = s1_px_r[c];
      if (!first_frame_r) begin
        upd.sum[c]  = cur.sum[c] + SW'(s1_px_r[c]);
        upd.diff[c] = cur.diff[c] + SW'((s1_px_r[c] > cur.prev[c]) ?
                                        (s1_px_r[c] - cur.prev[c]) :
                                        (cur.prev[c] - s1_px_r[c]));
      end
    end
  end

  assign learn_wr = s1_adv && s1_learn && !s1_ign;
  assign wr_en    = clearing_r || learn_wr;
  assign wr_addr  = clearing_r ? clr_addr_r : s1_addr_r;
  assign wr_data  = clearing_r ? bgm_pkg::entry_t'('0) : upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_v_r <= 1'b0;
    end else if (learn_wr) begin
      fw_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (learn_wr) begin
      fw_addr_r <= s1_addr_r;
      fw_data_r <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_frame_r <= 1'b1;
      learned_r     <= '0;
    end else if (s1_adv && s1_learn && s1_last_r) begin
      if (first_frame_r) begin
        first_frame_r <= 1'b0;
      end else if (!s1_ign) begin
        learned_r <= learned_r + 1'b1;
      end
    end
  end

  // stage 1 products for classification
  logic [bgm_pkg::CNT_W-1:0]        n_cnt;
  logic [NC-1:0][bgm_pkg::SPREAD_W-1:0] spread;

  assign n_cnt = (learned_r == '0) ? bgm_pkg::CNT_W'(1) : learned_r;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      spread[c] = bgm_pkg::SPREAD_W'(cur.diff[c]) + bgm_pkg::SPREAD_W'(n_cnt);
    end
  end

  logic                  s2_op_r;
  logic                  s2_ign_r;
  logic [NC-1:0][SW-1:0] s2_sum_r;
  logic [NC-1:0][PW-1:0] s2_lo_r;
  logic [NC-1:0][PW-1:0] s2_hi_r;
  logic [NC-1:0][NPW-1:0] s2_np_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_op_r  <= s1_op_r;
      s2_ign_r <= s1_learn && s1_ign;
      for (int c = 0; c < NC; c++) begin
        s2_sum_r[c] <= cur.sum[c];
        s2_lo_r[c]  <= PW'(low_scale_r) * PW'(spread[c]);
        s2_hi_r[c]  <= PW'(high_scale_r) * PW'(spread[c]);
        s2_np_r[c]  <= NPW'(n_cnt) * NPW'(s1_px_r[c]);
      end
    end
  end

  // stage 2 band test
  logic          any_in;
  logic [MW-1:0] centre;
  logic [MW-1:0] val;

  always_comb begin
    any_in = 1'b0;
    centre = '0;
    val    = '0;
    for (int c = 0; c < NC; c++) begin
      centre = MW'({s2_sum_r[c], 4'b0000});
      val    = MW'({s2_np_r[c], 4'b0000});
      if ((centre <= val + MW'(s2_lo_r[c])) && (val < centre + MW'(s2_hi_r[c]))) begin
        any_in = 1'b1;
      end
    end
  end

  // output register
  logic out_fg_r;
  logic out_ign_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s2_v_r) begin
      out_fg_r  <= (s2_op_r == bgm_pkg::OP_CLASSIFY) && !any_in;
      out_ign_r <= s2_ign_r;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.foreground    = out_fg_r;
  assign out_bus.learn_ignored = out_ign_r;

endmodule

FILE: rtl/core/bgm_entry_ram.sv
// ----------------------------------------------------------------------------
// bgm_entry_ram: per-pixel model store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bgm_entry_ram (
  input  logic            clk,
  input  logic            rd_en,
  input  bgm_pkg::addr_t  rd_addr,
  output bgm_pkg::entry_t rd_data,
  input  logic            wr_en,
  input  bgm_pkg::addr_t  wr_addr,
  input  bgm_pkg::entry_t wr_data
);

  bgm_pkg::entry_t mem [bgm_pkg::PIXELS];
  bgm_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
